@@ rtl/next_fit_free_list_allocator_assert.svh @@
// assertion macros shared by the allocator checker
// no dependencies
`ifndef NEXT_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define NEXT_FIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define NFA_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// next-cycle implication
`define NFA_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

@@ rtl/nfa_pkg.sv @@
// shared types for the next-fit allocator
// no dependencies
package nfa_pkg;
    localparam int ADDR_W = 12;
    localparam int SIZE_W = 19;

    localparam logic       ACT_ALLOC = 1'b0;
    localparam logic       ACT_FREE  = 1'b1;
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_OOM    = 2'd1;
    localparam logic [1:0] ST_ZERO   = 2'd2;

    typedef struct packed {
        logic              action;
        logic [SIZE_W-1:0] size_bits;
        logic [ADDR_W-1:0] block_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [1:0]        status;
    } rsp_t;
endpackage

@@ rtl/next_fit_free_list_allocator.sv @@
// next-fit free-list allocator top level
// depends on nfa_pkg
//
// one request per start beat, taken at an edge where busy is low; busy stays high while
// the request walks the free list and through the cycle of its done beat. an allocate
// runs S_ARD, S_AWAIT, S_ACHK on each free block that is too small (up to two passes,
// each capped at ARENA_UNITS+1 steps), the same states to fetch the rover's link when the
// rover is a real block, a further S_ACHK when the search wraps to the head, S_ARD and
// S_AWAIT to read the block that fits, then S_AUPD, S_AFIN, S_RESP and the done beat. a
// free runs S_FCHK, S_FRD, S_FWAIT on each free block below the freed address, S_FCHK to
// test the block above it plus S_FRD, S_FWAIT to read it when there is one, then S_FQRD,
// S_FQWAIT, S_FUPD, S_FQWR, S_RESP and the done beat. a zero size or an out-of-range
// request goes straight to S_RESP. the walk time is set by the single-port link and size
// memories, each read once a step with registered data. after reset a clearing pass is
// not needed: only entry 0 is meaningful and it is written in the S_INIT step. results
// show on result for one cycle with done high; the receiver cannot stall, so nothing is ever held back.
module next_fit_free_list_allocator
    import nfa_pkg::*;
#(
    parameter int ARENA_UNITS = 4096,
    parameter int UNIT_BYTES  = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t request,
    output logic busy,
    output logic done,
    output rsp_t result
);
    // pointer values: 0..ARENA_UNITS-1 units, ARENA_UNITS nil, ARENA_UNITS+1 head marker
    localparam int PW = $clog2(ARENA_UNITS + 2);
    localparam int IW = $clog2(ARENA_UNITS);
    localparam int BW = $clog2(UNIT_BYTES);
    localparam logic [PW-1:0] NIL  = PW'(ARENA_UNITS);
    localparam logic [PW-1:0] HEAD = PW'(ARENA_UNITS + 1);
    localparam logic [PW:0]   LIMIT = (PW+1)'(ARENA_UNITS + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ARD, S_AWAIT, S_ACHK, S_AUPD, S_AFIN,
        S_FRD, S_FWAIT, S_FCHK, S_FQRD, S_FQWAIT, S_FUPD, S_FQWR, S_RESP
    } state_t;

    state_t state_reg;
    logic [PW-1:0] link_mem [ARENA_UNITS];
    logic [PW-1:0] size_mem [ARENA_UNITS];

    logic [PW-1:0] head_reg, rover_reg, q_reg, p_reg;
    logic [PW-1:0] need_reg, r_reg;
    logic [PW:0]   steps_reg;
    logic          pass_reg;
    logic          first_reg;  // rover is a real block: its link is fetched first
    logic [PW-1:0] lrd_reg, srd_reg;  // registered memory read data
    logic [PW-1:0] plink_reg, psize_reg, qsize_reg;
    logic [PW-1:0] grant_reg;
    logic [1:0]    status_reg;
    logic          done_reg;

    // memory port: one address, read and optional writes
    logic [IW-1:0] maddr;
    logic          lwe, swe;
    logic [PW-1:0] lwd, swd;

    // size rounding: bits to bytes to units
    logic [SIZE_W-1:0] bytes_w;
    logic [SIZE_W:0]   units_w;
    always_comb
    begin
        bytes_w = SIZE_W'(((SIZE_W+1)'(request.size_bits) + (SIZE_W+1)'(7)) >> 3);
        units_w = ((SIZE_W+1)'(bytes_w) + (SIZE_W+1)'(UNIT_BYTES - 1)) >> BW;
    end

    always_ff @(posedge clk)
    begin
        if (lwe) link_mem[maddr] <= lwd;
        if (swe) size_mem[maddr] <= swd;
        lrd_reg <= link_mem[maddr];
        srd_reg <= size_mem[maddr];
    end

    // end of the block below (q plus its size), used by the free update merge test
    logic [PW:0] sum_w;
    assign sum_w = (PW+1)'(q_reg) + (PW+1)'(qsize_reg);

    // free update: merge with the block above (p) and below (q)
    logic          merge_r_w, merge_l_w;
    logic [PW-1:0] flink_w, fsize_w;
    always_comb
    begin
        merge_r_w = (p_reg < NIL) && (p_reg == r_reg + need_reg);
        merge_l_w = (q_reg < NIL) && (sum_w == (PW+1)'(r_reg));
        flink_w   = merge_r_w ? plink_reg : ((p_reg < NIL) ? p_reg : NIL);
        fsize_w   = need_reg + (merge_r_w ? psize_reg : '0);
    end

    always_comb
    begin
        maddr = '0; lwe = 1'b0; swe = 1'b0; lwd = '0; swd = '0;
        unique case (state_reg)
            S_INIT:
            begin
                lwe = 1'b1; swe = 1'b1; lwd = NIL; swd = PW'(ARENA_UNITS);
            end
            S_ARD, S_FRD: maddr = p_reg[IW-1:0];
            S_AUPD:
            begin
                maddr = p_reg[IW-1:0];
                if (psize_reg != need_reg)
                begin
                    swe = 1'b1; swd = psize_reg - need_reg;
                end
            end
            S_AFIN:
            begin
                maddr = q_reg[IW-1:0];
                if (psize_reg == need_reg && q_reg < NIL)
                begin
                    lwe = 1'b1; lwd = plink_reg;
                end
            end
            S_FQRD: maddr = q_reg[IW-1:0];
            S_FUPD:
            begin
                // freed block: link always, size only when it stays a block of its own
                maddr = r_reg[IW-1:0]; lwe = 1'b1; lwd = flink_w;
                if (!merge_l_w)
                begin
                    swe = 1'b1; swd = fsize_w;
                end
            end
            S_FQWR:
            begin
                // block below: absorbs the freed block or links to it
                if (q_reg < NIL)
                begin
                    maddr = q_reg[IW-1:0]; lwe = 1'b1;
                    if (merge_l_w)
                    begin
                        lwd = flink_w; swe = 1'b1; swd = qsize_reg + fsize_w;
                    end
                    else lwd = r_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            head_reg <= '0;
            rover_reg <= HEAD;
            q_reg <= '0;
            p_reg <= '0;
            need_reg <= '0;
            r_reg <= '0;
            steps_reg <= '0;
            pass_reg <= 1'b0;
            first_reg <= 1'b0;
            plink_reg <= '0;
            psize_reg <= '0;
            qsize_reg <= '0;
            grant_reg <= '0;
            status_reg <= ST_DONE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_INIT: state_reg <= S_IDLE;
                S_IDLE:
                begin
                    if (start && !done_reg)
                    begin
                        need_reg <= PW'(units_w);
                        r_reg <= PW'(request.block_address);
                        steps_reg <= '0;
                        pass_reg <= 1'b0;
                        if (request.size_bits == '0)
                        begin
                            grant_reg <= '0; status_reg <= ST_ZERO; state_reg <= S_RESP;
                        end
                        else if (request.action == ACT_ALLOC)
                        begin
                            // units_w above the arena can never fit
                            if (units_w > (SIZE_W+1)'(ARENA_UNITS))
                            begin
                                grant_reg <= '0; status_reg <= ST_OOM; state_reg <= S_RESP;
                            end
                            else if (rover_reg >= NIL)
                            begin
                                q_reg <= HEAD; p_reg <= head_reg; state_reg <= S_ACHK;
                            end
                            else
                            begin
                                q_reg <= rover_reg; p_reg <= rover_reg;
                                first_reg <= 1'b1; state_reg <= S_ARD;
                            end
                        end
                        else
                        begin
                            if ((SIZE_W+1)'(request.block_address) + units_w
                                > (SIZE_W+1)'(ARENA_UNITS))
                            begin
                                grant_reg <= '0; status_reg <= ST_OOM; state_reg <= S_RESP;
                            end
                            else
                            begin
                                q_reg <= HEAD; p_reg <= head_reg; state_reg <= S_FCHK;
                            end
                        end
                    end
                end
                S_ARD: state_reg <= S_AWAIT;
                S_AWAIT:
                begin
                    if (first_reg)
                    begin
                        // start: p = link(rover)
                        p_reg <= lrd_reg;
                        first_reg <= 1'b0;
                        state_reg <= S_ACHK;
                    end
                    else
                    begin
                        plink_reg <= lrd_reg; psize_reg <= srd_reg;
                        if (srd_reg < need_reg)
                        begin
                            if (steps_reg + 1'b1 > LIMIT) p_reg <= NIL;
                            else
                            begin
                                steps_reg <= steps_reg + 1'b1;
                                q_reg <= p_reg; p_reg <= lrd_reg;
                            end
                            state_reg <= S_ACHK;
                        end
                        else state_reg <= S_AUPD;
                    end
                end
                S_ACHK:
                begin
                    if (p_reg < NIL) state_reg <= S_ARD;
                    else if (!pass_reg)
                    begin
                        pass_reg <= 1'b1; steps_reg <= '0;
                        q_reg <= HEAD; p_reg <= head_reg;
                        if (head_reg >= NIL)
                        begin
                            grant_reg <= '0; status_reg <= ST_OOM; state_reg <= S_RESP;
                        end
                    end
                    else
                    begin
                        grant_reg <= '0; status_reg <= ST_OOM; state_reg <= S_RESP;
                    end
                end
                S_AUPD:
                begin
                    grant_reg <= (psize_reg == need_reg) ? p_reg
                                 : p_reg + (psize_reg - need_reg);
                    if (psize_reg == need_reg && q_reg == HEAD) head_reg <= plink_reg;
                    state_reg <= S_AFIN;
                end
                S_AFIN:
                begin
                    // rover = link(q) after the update
                    if (psize_reg == need_reg)
                        rover_reg <= (plink_reg >= NIL) ? HEAD : plink_reg;
                    else
                        rover_reg <= p_reg;
                    status_reg <= ST_DONE;
                    state_reg <= S_RESP;
                end
                S_FCHK:
                begin
                    if (p_reg < NIL) state_reg <= S_FRD;
                    else state_reg <= S_FQRD;
                end
                S_FRD: state_reg <= S_FWAIT;
                S_FWAIT:
                begin
                    plink_reg <= lrd_reg; psize_reg <= srd_reg;
                    if (p_reg < r_reg)
                    begin
                        if (steps_reg + 1'b1 > LIMIT)
                        begin
                            p_reg <= NIL; state_reg <= S_FQRD;
                        end
                        else
                        begin
                            steps_reg <= steps_reg + 1'b1;
                            q_reg <= p_reg; p_reg <= lrd_reg; state_reg <= S_FCHK;
                        end
                    end
                    else state_reg <= S_FQRD;
                end
                S_FQRD: state_reg <= S_FQWAIT;
                S_FQWAIT:
                begin
                    qsize_reg <= (q_reg < NIL) ? srd_reg : '0;
                    state_reg <= S_FUPD;
                end
                S_FUPD: state_reg <= S_FQWR;
                S_FQWR:
                begin
                    rover_reg <= q_reg;
                    grant_reg <= '0; status_reg <= ST_DONE;
                    if (!merge_l_w && q_reg == HEAD) head_reg <= r_reg;
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE) || done_reg;
    assign done = done_reg;
    assign result.granted_address = grant_reg[ADDR_W-1:0];
    assign result.status = status_reg;
endmodule

@@ rtl/nfa_checker.sv @@
// port-level checker for the allocator, bound to the top level
// depends on nfa_pkg and the assertion macro header
`include "next_fit_free_list_allocator_assert.svh"
module nfa_checker
    import nfa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t result
);
    // busy is high whenever a result beat is shown
    `NFA_ASSERT_IMP(a_done_busy, clk, rst_n, done, busy, "done without busy")
    // status code is one of the defined three
    `NFA_ASSERT_IMP(a_status, clk, rst_n, done, result.status != 2'd3, "bad status")
    // nothing granted on a result that is not a success
    `NFA_ASSERT_IMP(a_grant0, clk, rst_n, done && result.status != ST_DONE,
        result.granted_address == '0, "grant on failure")
    // accepted beat makes the block busy
    `NFA_ASSERT_NXT(a_busy, clk, rst_n, start && !busy, busy, "not busy after accept")
endmodule

bind next_fit_free_list_allocator nfa_checker u_nfa_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .result(result)
);

@@ dv/testbench.sv @@
// self-checking testbench for the next-fit free-list allocator
// depends on nfa_pkg and next_fit_free_list_allocator; predicts every beat in place
module testbench;
    import nfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ARENA     = 4096;
    localparam int UNIT_B    = 8;
    localparam int NIL       = ARENA;
    localparam int HEAD      = ARENA + 1;
    localparam int WALK_MAX  = ARENA + 1;
    localparam int N_RANDOM  = 700;
    localparam longint CYCLE_LIMIT = 64'd100_000_000;

    logic clk;
    logic rst_n;
    logic start;
    req_t request;
    logic busy;
    logic done;
    rsp_t result;

    next_fit_free_list_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // mirror of the allocator state
    int unsigned link_mem [ARENA];
    int unsigned size_mem [ARENA];
    int unsigned head_link;
    int unsigned rover_ptr;

    rsp_t   pending_rsp [$];
    int     error_count = 0;
    longint cycle_count = 0;

    // blocks handed out and not yet freed, used to build sensible frees
    int unsigned owned_addr [$];
    int unsigned owned_units [$];

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("next_fit_free_list_allocator verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                rsp_t want;
                want = pending_rsp.pop_front();
                if (result.granted_address !== want.granted_address)
                    report_mismatch("granted_address", int'(result.granted_address),
                                    int'(want.granted_address));
                if (result.status !== want.status)
                    report_mismatch("status", int'(result.status), int'(want.status));
            end
        end
    end

    function automatic int unsigned link_of(int unsigned x);
        if (x == HEAD) return head_link;
        if (x < ARENA) return link_mem[x];
        return NIL;
    endfunction

    function automatic void put_link(int unsigned x, int unsigned v);
        if (x == HEAD) head_link = v;
        else if (x < ARENA) link_mem[x] = v;
    endfunction

    function automatic int unsigned units_for(int unsigned bits);
        int unsigned nbytes;
        nbytes = (bits + 7) / 8;
        return (nbytes + UNIT_B - 1) / UNIT_B;
    endfunction

    function automatic void clear_state();
        foreach (link_mem[i])
        begin
            link_mem[i] = 0;
            size_mem[i] = 0;
        end
        link_mem[0] = NIL;
        size_mem[0] = ARENA;
        head_link = 0;
        rover_ptr = HEAD;
    endfunction

    // next-fit search from the rover, then once more from the head marker
    function automatic rsp_t predict_alloc(int unsigned need);
        rsp_t r;
        int unsigned q, p, steps, grant;
        bit found;
        r = '0;
        found = 0;
        q = (rover_ptr != HEAD && rover_ptr >= ARENA) ? HEAD : rover_ptr;
        p = link_of(q);
        for (int pass = 0; pass < 2; pass++)
        begin
            steps = 0;
            while (p < ARENA && size_mem[p] < need)
            begin
                steps++;
                if (steps > WALK_MAX)
                begin
                    p = NIL;
                    break;
                end
                q = p;
                p = link_of(p);
            end
            if (p < ARENA)
            begin
                found = 1;
                break;
            end
            if (pass == 0)
            begin
                q = HEAD;
                p = link_of(q);
            end
        end
        if (!found)
        begin
            r.status = ST_OOM;
            return r;
        end
        if (size_mem[p] == need)
        begin
            put_link(q, link_mem[p]);
            grant = p;
        end
        else
        begin
            size_mem[p] -= need;
            grant = p + size_mem[p];
        end
        rover_ptr = link_of(q);
        if (rover_ptr >= ARENA) rover_ptr = HEAD;
        r.granted_address = grant[ADDR_W-1:0];
        r.status = ST_DONE;
        return r;
    endfunction

    // address-ordered insert with merge on both sides
    function automatic rsp_t predict_free(int unsigned addr, int unsigned n);
        rsp_t r;
        int unsigned q, p, steps;
        r = '0;
        if (addr >= ARENA || n > ARENA - addr)
        begin
            r.status = ST_OOM;
            return r;
        end
        q = HEAD;
        p = link_of(q);
        steps = 0;
        while (p < ARENA && p < addr)
        begin
            steps++;
            if (steps > WALK_MAX)
            begin
                p = NIL;
                break;
            end
            q = p;
            p = link_of(p);
        end
        if (p < ARENA && p == addr + n)
        begin
            n += size_mem[p];
            link_mem[addr] = link_mem[p];
        end
        else
            link_mem[addr] = (p < ARENA) ? p : NIL;
        if (q < ARENA && addr == q + size_mem[q])
        begin
            size_mem[q] += n;
            link_mem[q] = link_mem[addr];
        end
        else
        begin
            put_link(q, addr);
            size_mem[addr] = n;
        end
        rover_ptr = q;
        r.status = ST_DONE;
        return r;
    endfunction

    function automatic rsp_t predict_request(req_t rq);
        if (rq.size_bits == 0)
        begin
            rsp_t r;
            r = '0;
            r.status = ST_ZERO;
            return r;
        end
        if (rq.action == ACT_ALLOC)
            return predict_alloc(units_for(32'(rq.size_bits)));
        return predict_free(32'(rq.block_address), units_for(32'(rq.size_bits)));
    endfunction

    // one beat: hold start until busy is low at an edge
    task automatic send_beat(input req_t rq);
        rsp_t want;
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy) @(posedge clk);
        want = predict_request(rq);
        pending_rsp.push_back(want);
        if (rq.action == ACT_ALLOC && rq.size_bits != 0 && want.status == ST_DONE)
        begin
            owned_addr.push_back(32'(want.granted_address));
            owned_units.push_back(units_for(32'(rq.size_bits)));
        end
    endtask

    task automatic idle_gap();
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if (n == 0) return;
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0 || busy) @(posedge clk);
    endtask

    // directed rows; a known answer is given where it is obvious, else the predictor decides
    typedef struct {
        req_t rq;
        bit   known;
        rsp_t want;
    } row_t;

    function automatic row_t mk(logic act, int unsigned bits, int unsigned addr,
                                bit known, int unsigned ga, logic [1:0] st);
        row_t r;
        r.rq.action = act;
        r.rq.size_bits = bits[SIZE_W-1:0];
        r.rq.block_address = addr[ADDR_W-1:0];
        r.known = known;
        r.want.granted_address = ga[ADDR_W-1:0];
        r.want.status = st;
        return r;
    endfunction

    row_t directed [$];

    initial
    begin
        req_t rq;
        int unsigned k, units, addr;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        clear_state();

        // zero size, both actions, all ones address
        directed.push_back(mk(ACT_ALLOC, 0, 4095, 1, 0, ST_ZERO));
        directed.push_back(mk(ACT_FREE, 0, 4095, 1, 0, ST_ZERO));
        // larger than the arena, and the maximum encodable size
        directed.push_back(mk(ACT_ALLOC, 262145, 0, 1, 0, ST_OOM));
        directed.push_back(mk(ACT_ALLOC, 524287, 0, 1, 0, ST_OOM));
        // free outside the arena
        directed.push_back(mk(ACT_FREE, 128, 4095, 1, 0, ST_OOM));
        // one bit takes the top unit after a split
        directed.push_back(mk(ACT_ALLOC, 1, 0, 1, 4095, ST_DONE));
        directed.push_back(mk(ACT_ALLOC, 65, 0, 1, 4093, ST_DONE));
        directed.push_back(mk(ACT_ALLOC, 64, 0, 0, 0, ST_DONE));
        // frees that merge not at all, below, and on both sides
        directed.push_back(mk(ACT_FREE, 1, 4095, 0, 0, ST_DONE));
        directed.push_back(mk(ACT_FREE, 64, 4092, 0, 0, ST_DONE));
        directed.push_back(mk(ACT_FREE, 128, 4093, 0, 0, ST_DONE));
        // whole arena back in one block, then all of it taken exactly
        directed.push_back(mk(ACT_ALLOC, 262144, 0, 1, 0, ST_DONE));
        directed.push_back(mk(ACT_ALLOC, 1, 0, 1, 0, ST_OOM));
        directed.push_back(mk(ACT_FREE, 262144, 0, 1, 0, ST_DONE));
        // carve a hole and exercise the rover wrap
        directed.push_back(mk(ACT_ALLOC, 1024, 0, 0, 0, ST_DONE));
        directed.push_back(mk(ACT_ALLOC, 2048, 0, 0, 0, ST_DONE));
        directed.push_back(mk(ACT_FREE, 1024, 4080, 0, 0, ST_DONE));
        directed.push_back(mk(ACT_ALLOC, 512, 0, 0, 0, ST_DONE));
        directed.push_back(mk(ACT_ALLOC, 200000, 0, 0, 0, ST_DONE));
        // double free is not detected
        directed.push_back(mk(ACT_FREE, 512, 4080, 0, 0, ST_DONE));
        directed.push_back(mk(ACT_FREE, 512, 4080, 0, 0, ST_DONE));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            rsp_t p;
            send_beat(directed[i].rq);
            p = pending_rsp[pending_rsp.size() - 1];
            if (directed[i].known && p != directed[i].want)
                report_mismatch("directed row predictor", int'(p), int'(directed[i].want));
            idle_gap();
        end

        // hold off until the block has answered everything, then hand the whole arena back
        drain();
        owned_addr.delete();
        owned_units.delete();
        rq = '0;
        rq.action = ACT_FREE;
        rq.size_bits = 19'd262144;
        rq.block_address = '0;
        send_beat(rq);
        drain();

        for (k = 0; k < N_RANDOM; k++)
        begin
            int unsigned pick;
            rq = '0;
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                rq.action = 1'($urandom_range(0, 1));
                rq.block_address = ADDR_W'($urandom);
            end
            else if (pick < 8)
            begin
                // noise: any size, any address
                rq.action = 1'($urandom_range(0, 1));
                rq.size_bits = SIZE_W'($urandom);
                rq.block_address = ADDR_W'($urandom);
            end
            else if (pick < 55 || owned_addr.size() == 0)
            begin
                rq.action = ACT_ALLOC;
                units = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 1024)
                                                    : $urandom_range(1, 24);
                rq.size_bits = SIZE_W'(units * UNIT_B * 8
                                       - $urandom_range(0, UNIT_B * 8 - 1));
            end
            else
            begin
                // well-formed free of a block we hold
                pick = $urandom_range(0, owned_addr.size() - 1);
                addr = owned_addr[pick];
                units = owned_units[pick];
                owned_addr.delete(pick);
                owned_units.delete(pick);
                rq.action = ACT_FREE;
                rq.block_address = ADDR_W'(addr);
                rq.size_bits = SIZE_W'(units * UNIT_B * 8
                                       - $urandom_range(0, UNIT_B * 8 - 1));
            end
            send_beat(rq);
            if (k % 150 < 20)
                ; // back-to-back stretch
            else
                idle_gap();
        end

        drain();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("next_fit_free_list_allocator verification clean");
        else
            $display("next_fit_free_list_allocator verification failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+rtl
rtl/nfa_pkg.sv
rtl/next_fit_free_list_allocator.sv
rtl/nfa_checker.sv
dv/testbench.sv
